// ===== hw/rtl/brot_pkg.sv =====
// Shared types and constants for the 90 degree bitmap rotator.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package brot_pkg;

   localparam int ADDR_W       = 26;
   localparam int BYTE_W       = 8;
   localparam int DIM_W        = 13;
   localparam int STRIDE_W     = 15;
   localparam int MODE_W       = 3;
   localparam int CSR_INDEX_W  = 3;
   localparam int CSR_DATA_W   = 15;
   localparam int RSP_TDATA_W  = 48;
   localparam int RSP_PAD_W    = RSP_TDATA_W - ADDR_W - 2 * BYTE_W;
   localparam int COUNT_W      = 4;
   localparam int POS_W        = 3;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_SRC_STRIDE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_DST_STRIDE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BPP_MODE   = 3'd4;

   // pixel formats
   localparam logic [MODE_W-1:0] MODE_1BPP  = 3'd0;
   localparam logic [MODE_W-1:0] MODE_4BPP  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_8BPP  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_16BPP = 3'd3;
   localparam logic [MODE_W-1:0] MODE_24BPP = 3'd4;
   localparam logic [MODE_W-1:0] MODE_32BPP = 3'd5;

   localparam logic [BYTE_W-1:0] BIT_MASK    = 8'h01;
   localparam logic [BYTE_W-1:0] NIBBLE_MASK = 8'h0F;
   localparam logic [BYTE_W-1:0] FULL_MASK   = 8'hFF;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   typedef enum logic [1:0] {
      KIND_BIT    = 2'd0,
      KIND_NIBBLE = 2'd1,
      KIND_BYTE   = 2'd2
   } kind_type;

   typedef struct packed {
      logic [DIM_W-1:0]    src_width;
      logic [DIM_W-1:0]    src_height;
      logic [STRIDE_W-1:0] src_stride;
      logic [STRIDE_W-1:0] dst_stride;
      logic [MODE_W-1:0]   bpp_mode;
   } cfg_type;

   // one source byte's worth of writes
   typedef struct packed {
      logic [ADDR_W-1:0]  addr;
      logic [BYTE_W-1:0]  src_byte;
      kind_type           kind;
      logic [COUNT_W-1:0] count;
      logic [POS_W-1:0]   pos;
      logic               frame_last;
   } entry_type;

endpackage

`default_nettype wire

// ===== hw/rtl/brot_front.sv =====
// Front end: accepts source bytes, keeps the raster counters and turns each
// byte that has writes into one descriptor of them. Depends on brot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brot_front #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire brot_pkg::cfg_type   cfg,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,
   output logic                     push_valid,
   input  wire logic                push_ready,
   output brot_pkg::entry_type      push_entry
);

   localparam int DW = $clog2(MAX_DIM + 1);
   localparam int YW = $clog2(MAX_DIM);
   localparam int CW = YW + 2;
   localparam int KW = (DW > brot_pkg::DIM_W) ? DW : brot_pkg::DIM_W;
   localparam int PW = brot_pkg::STRIDE_W + DW;
   localparam int SW = PW + 1;
   localparam int BW = brot_pkg::STRIDE_W + 1;

   logic [YW-1:0]                 row_ff, row_in;
   logic [DW-1:0]                 col_ff, col_in;
   logic [1:0]                    k_ff, k_in;
   logic [brot_pkg::STRIDE_W-1:0] bir_ff, bir_in;

   logic                          s1_valid_ff, s1_valid_in;
   logic [DW-1:0]                 s1_x_ff;
   logic [CW-1:0]                 s1_coloff_ff;
   logic [7:0]                    s1_byte_ff;
   brot_pkg::kind_type            s1_kind_ff;
   logic [brot_pkg::COUNT_W-1:0]  s1_count_ff;
   logic [brot_pkg::POS_W-1:0]    s1_pos_ff;
   logic                          s1_flast_ff;

   logic [KW-1:0]                 wide_w, wide_h;
   logic [DW-1:0]                 w, h, rem;
   logic [YW-1:0]                 col;
   logic                          row_ok, last_row, x_lt_w, pix_done, acc;
   logic [2:0]                    pbn;
   logic [brot_pkg::COUNT_W-1:0]  n;
   brot_pkg::kind_type            kind;
   logic [brot_pkg::POS_W-1:0]    pos;
   logic [CW-1:0]                 coloff;
   logic                          flast;
   logic [PW-1:0]                 prod;
   logic [SW-1:0]                 sum;

   assign wide_w = KW'(cfg.src_width);
   assign wide_h = KW'(cfg.src_height);
   assign w = (wide_w > KW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(wide_w);
   assign h = (wide_h > KW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(wide_h);

   assign row_ok   = DW'(row_ff) < h;
   assign col      = row_ok ? YW'(h - DW'(1) - DW'(row_ff)) : '0;
   assign last_row = row_ok && (DW'(row_ff) + DW'(1) == h);
   assign x_lt_w   = col_ff < w;
   assign rem      = w - col_ff;
   assign pbn      = cfg.bpp_mode - 3'd1;
   assign pix_done = (3'(k_ff) + 3'd1) >= pbn;

   assign req_tready = !s1_valid_ff || push_ready;
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      n      = '0;
      kind   = brot_pkg::KIND_BYTE;
      pos    = '0;
      coloff = '0;
      flast  = 1'b0;
      col_in = col_ff;
      k_in   = k_ff;
      unique case (cfg.bpp_mode)
         brot_pkg::MODE_1BPP: begin
            kind   = brot_pkg::KIND_BIT;
            pos    = ~col[2:0];
            coloff = CW'(col >> 3);
            flast  = last_row && (rem <= DW'(8));
            if (x_lt_w) begin
               col_in = (rem > DW'(8)) ? col_ff + DW'(8) : w;
               if (row_ok) begin
                  n = (rem >= DW'(8)) ? 4'd8 : 4'(rem);
               end
            end
         end
         brot_pkg::MODE_4BPP: begin
            kind   = brot_pkg::KIND_NIBBLE;
            pos    = {~col[0], 2'b00};
            coloff = CW'(col >> 1);
            flast  = last_row && (rem <= DW'(2));
            if (x_lt_w) begin
               col_in = (rem > DW'(2)) ? col_ff + DW'(2) : w;
               if (row_ok) begin
                  n = (rem >= DW'(2)) ? 4'd2 : 4'(rem);
               end
            end
         end
         brot_pkg::MODE_8BPP, brot_pkg::MODE_16BPP,
         brot_pkg::MODE_24BPP, brot_pkg::MODE_32BPP: begin
            unique case (cfg.bpp_mode)
               brot_pkg::MODE_8BPP:  coloff = CW'(col);
               brot_pkg::MODE_16BPP: coloff = CW'(col) << 1;
               brot_pkg::MODE_24BPP: coloff = (CW'(col) << 1) + CW'(col);
               default:              coloff = CW'(col) << 2;
            endcase
            coloff = coloff + CW'(k_ff);
            flast  = last_row && (rem == DW'(1)) && pix_done;
            if (x_lt_w) begin
               if (row_ok) begin
                  n = 4'd1;
               end
               if (pix_done) begin
                  k_in   = 2'd0;
                  col_in = col_ff + DW'(1);
               end else begin
                  k_in = k_ff + 2'd1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // row end overrides the per-format counter updates
   always_comb begin
      row_in = row_ff;
      bir_in = bir_ff;
      if ((BW'(bir_ff) + BW'(1)) >= BW'(cfg.src_stride)) begin
         bir_in = '0;
         row_in = ((DW'(row_ff) + DW'(1)) >= h) ? '0 : row_ff + YW'(1);
      end else begin
         bir_in = bir_ff + brot_pkg::STRIDE_W'(1);
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (acc) begin
         s1_valid_in = (n != '0);
      end else if (push_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         bir_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         if (acc) begin
            row_ff <= row_in;
            bir_ff <= bir_in;
            if (bir_in == '0) begin
               col_ff <= '0;
               k_ff   <= '0;
            end else begin
               col_ff <= col_in;
               k_ff   <= k_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_x_ff      <= col_ff;
         s1_coloff_ff <= coloff;
         s1_byte_ff   <= req_tdata;
         s1_kind_ff   <= kind;
         s1_count_ff  <= n;
         s1_pos_ff    <= pos;
         s1_flast_ff  <= flast;
      end
   end

   // base address of the first write; later ones step by dst_stride
   assign prod = PW'(cfg.dst_stride) * PW'(s1_x_ff);
   assign sum  = SW'(prod) + SW'(s1_coloff_ff);

   assign push_valid            = s1_valid_ff;
   assign push_entry.addr       = brot_pkg::ADDR_W'(sum);
   assign push_entry.src_byte   = s1_byte_ff;
   assign push_entry.kind       = s1_kind_ff;
   assign push_entry.count      = s1_count_ff;
   assign push_entry.pos        = s1_pos_ff;
   assign push_entry.frame_last = s1_flast_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/brot_queue.sv =====
// Short descriptor queue between front end and write issuer.
// Depends on brot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brot_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                wr_valid,
   output logic                     wr_ready,
   input  wire brot_pkg::entry_type wr_entry,
   output logic                     rd_valid,
   input  wire logic                rd_ready,
   output brot_pkg::entry_type      rd_entry
);

   brot_pkg::entry_type                store_ff [brot_pkg::QUEUE_DEPTH];
   logic [brot_pkg::QUEUE_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [brot_pkg::QUEUE_CNT_W-1:0]   count_ff, count_in;
   logic                               push, pop;

   assign wr_ready = count_ff != brot_pkg::QUEUE_CNT_W'(brot_pkg::QUEUE_DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_entry = store_ff[rd_ptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + brot_pkg::QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - brot_pkg::QUEUE_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + brot_pkg::QUEUE_PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + brot_pkg::QUEUE_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= brot_pkg::QUEUE_CNT_W'(brot_pkg::QUEUE_DEPTH))
      else $error("descriptor queue count beyond depth");

endmodule

`default_nettype wire

// ===== hw/rtl/brot_back.sv =====
// Write issuer: expands each descriptor into masked writes, one per cycle
// while the registered output stage is not stalled. Depends on brot_pkg.
`timescale 1ns / 1ps
`default_nettype none

module brot_back (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic [brot_pkg::STRIDE_W-1:0] dst_stride,
   input  wire logic                       pop_valid,
   output logic                            pop_ready,
   input  wire brot_pkg::entry_type        pop_entry,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [brot_pkg::ADDR_W-1:0]     rsp_addr,
   output logic [brot_pkg::BYTE_W-1:0]     rsp_data,
   output logic [brot_pkg::BYTE_W-1:0]     rsp_mask,
   output logic                            rsp_run_last,
   output logic                            rsp_frame_last
);

   logic                          cur_valid_ff, cur_valid_in;
   logic [brot_pkg::ADDR_W-1:0]   cur_addr_ff;
   logic [brot_pkg::BYTE_W-1:0]   cur_byte_ff;
   brot_pkg::kind_type            cur_kind_ff;
   logic [brot_pkg::COUNT_W-1:0]  cur_left_ff;
   logic [brot_pkg::POS_W-1:0]    cur_pos_ff;
   logic                          cur_flast_ff;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [brot_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [brot_pkg::BYTE_W-1:0]   rsp_data_ff, rsp_mask_ff;
   logic                          rsp_last_ff, rsp_flast_ff;

   logic                          slot_free, adv, cur_last, take;
   logic [brot_pkg::BYTE_W-1:0]   wr_data, wr_mask, next_byte;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign adv       = cur_valid_ff && slot_free;
   assign cur_last  = cur_left_ff == brot_pkg::COUNT_W'(1);
   assign take      = !cur_valid_ff || (adv && cur_last);
   assign pop_ready = take;

   // pixels leave MSB first, so the byte shifts left after each write
   always_comb begin
      unique case (cur_kind_ff)
         brot_pkg::KIND_BIT: begin
            wr_data   = brot_pkg::BYTE_W'(cur_byte_ff[7]) << cur_pos_ff;
            wr_mask   = brot_pkg::BIT_MASK << cur_pos_ff;
            next_byte = cur_byte_ff << 1;
         end
         brot_pkg::KIND_NIBBLE: begin
            wr_data   = brot_pkg::BYTE_W'(cur_byte_ff[7:4]) << cur_pos_ff;
            wr_mask   = brot_pkg::NIBBLE_MASK << cur_pos_ff;
            next_byte = cur_byte_ff << 4;
         end
         default: begin
            wr_data   = cur_byte_ff;
            wr_mask   = brot_pkg::FULL_MASK;
            next_byte = cur_byte_ff;
         end
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      if (take) begin
         cur_valid_in = pop_valid;
      end
      rsp_valid_in = rsp_valid_ff;
      if (slot_free) begin
         rsp_valid_in = cur_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_addr_ff  <= pop_entry.addr;
         cur_byte_ff  <= pop_entry.src_byte;
         cur_kind_ff  <= pop_entry.kind;
         cur_left_ff  <= pop_entry.count;
         cur_pos_ff   <= pop_entry.pos;
         cur_flast_ff <= pop_entry.frame_last;
      end else if (adv) begin
         cur_addr_ff <= cur_addr_ff + brot_pkg::ADDR_W'(dst_stride);
         cur_byte_ff <= next_byte;
         cur_left_ff <= cur_left_ff - brot_pkg::COUNT_W'(1);
      end
      if (adv) begin
         rsp_addr_ff  <= cur_addr_ff;
         rsp_data_ff  <= wr_data;
         rsp_mask_ff  <= wr_mask;
         rsp_last_ff  <= cur_last;
         rsp_flast_ff <= cur_last && cur_flast_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_addr       = rsp_addr_ff;
   assign rsp_data       = rsp_data_ff;
   assign rsp_mask       = rsp_mask_ff;
   assign rsp_run_last   = rsp_last_ff;
   assign rsp_frame_last = rsp_flast_ff;

   a_flast_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_flast_ff |-> rsp_last_ff)
      else $error("frame end on a write that does not end its item");

   a_left_nonzero: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> cur_left_ff != '0)
      else $error("active descriptor with no writes left");

   a_data_in_mask: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff & ~rsp_mask_ff) == '0)
      else $error("write data outside its mask");

endmodule

`default_nettype wire

// ===== hw/rtl/bitmap_rotate_90.sv =====
// Top level of the 90 degree bitmap rotator: configuration registers and
// the front end, descriptor queue and write issuer. Depends on brot_pkg.
//
// Source bytes enter in raster order; each yields zero to eight masked
// destination writes, with source pixel (x,y) landing at destination row x,
// column src_height-1-y. The write issuer puts out one write per clock while
// the output is not stalled: up to 8 per byte in 1 bpp, up to 2 in 4 bpp, 1
// in the byte-wide formats; padding bytes produce nothing. A four-entry
// descriptor queue lets the input run ahead while writes drain. Each write
// passes the front-end register, the queue and the descriptor and output
// registers. Registers may be changed only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module bitmap_rotate_90 #(
   parameter int MAX_DIM = 4096
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,      // src_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,      // dst_addr, write_data, write_mask
   output logic             rsp_tlast,      // run_last
   output logic [0:0]       rsp_tuser,      // frame_last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [14:0] csr_data
);

   brot_pkg::cfg_type              cfg_ff;
   logic                           push_valid, push_ready, pop_valid, pop_ready;
   brot_pkg::entry_type            push_entry, pop_entry;
   logic [brot_pkg::ADDR_W-1:0]    rsp_addr;
   logic [brot_pkg::BYTE_W-1:0]    rsp_data, rsp_mask;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.src_width  <= brot_pkg::DIM_W'(1);
         cfg_ff.src_height <= brot_pkg::DIM_W'(1);
         cfg_ff.src_stride <= brot_pkg::STRIDE_W'(4);
         cfg_ff.dst_stride <= brot_pkg::STRIDE_W'(4);
         cfg_ff.bpp_mode   <= brot_pkg::MODE_8BPP;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            brot_pkg::REG_SRC_WIDTH:  cfg_ff.src_width  <= csr_data[12:0];
            brot_pkg::REG_SRC_HEIGHT: cfg_ff.src_height <= csr_data[12:0];
            brot_pkg::REG_SRC_STRIDE: cfg_ff.src_stride <= csr_data;
            brot_pkg::REG_DST_STRIDE: cfg_ff.dst_stride <= csr_data;
            brot_pkg::REG_BPP_MODE:   cfg_ff.bpp_mode   <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   brot_front #(
      .MAX_DIM (MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   brot_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_entry (push_entry),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_entry (pop_entry)
   );

   brot_back u_back (
      .clock          (clock),
      .reset          (reset),
      .dst_stride     (cfg_ff.dst_stride),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_addr       (rsp_addr),
      .rsp_data       (rsp_data),
      .rsp_mask       (rsp_mask),
      .rsp_run_last   (rsp_tlast),
      .rsp_frame_last (rsp_tuser[0])
   );

   assign rsp_tdata = {{brot_pkg::RSP_PAD_W{1'b0}}, rsp_mask, rsp_data, rsp_addr};

endmodule

`default_nettype wire

// ===== dv/bitmap_rotate_90_tb.sv =====
// Self-checking bench for bitmap_rotate_90: streams source bytes, predicts every
// masked destination write of the 90 degree rotation and checks each one in order.
// Depends on brot_pkg and the bitmap_rotate_90 top level.
`timescale 1ns / 1ps

module bitmap_rotate_90_tb;

   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [brot_pkg::CSR_INDEX_W-1:0] REG_UNMAPPED = 3'd7;
   localparam logic [brot_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
   localparam logic [brot_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;
   // 00 FF 80 01 AA 55 7F FE, lowest byte first
   localparam logic [63:0] EDGE_BYTES = 64'hFE7F_55AA_0180_FF00;

   typedef struct packed {
      logic [brot_pkg::ADDR_W-1:0] addr;
      logic [brot_pkg::BYTE_W-1:0] data;
      logic [brot_pkg::BYTE_W-1:0] mask;
      logic                        run_last;
      logic                        frame_last;
   } dst_write_type;

   class rotation_checker;
      localparam int unsigned MAX_SIDE = 4096;
      int unsigned src_width, src_height, src_stride, dst_stride;
      logic [brot_pkg::MODE_W-1:0] bpp_mode;
      int unsigned row_y, row_byte, col_x, pixel_byte;
      dst_write_type expected_writes[$];
      int unsigned mismatches;

      function new();
         src_width  = 1;
         src_height = 1;
         src_stride = 4;
         dst_stride = 4;
         bpp_mode   = brot_pkg::MODE_8BPP;
         row_y      = 0;
         row_byte   = 0;
         col_x      = 0;
         pixel_byte = 0;
         mismatches = 0;
      endfunction

      function void set_reg(logic [brot_pkg::CSR_INDEX_W-1:0] sel,
                            logic [brot_pkg::CSR_DATA_W-1:0] value);
         case (sel)
            brot_pkg::REG_SRC_WIDTH:  src_width  = value[brot_pkg::DIM_W-1:0];
            brot_pkg::REG_SRC_HEIGHT: src_height = value[brot_pkg::DIM_W-1:0];
            brot_pkg::REG_SRC_STRIDE: src_stride = value;
            brot_pkg::REG_DST_STRIDE: dst_stride = value;
            brot_pkg::REG_BPP_MODE:   bpp_mode   = value[brot_pkg::MODE_W-1:0];
            default: ;
         endcase
      endfunction

      function void add_write(int unsigned addr, int unsigned data, int unsigned mask,
                              bit is_end);
         dst_write_type wr;
         wr.addr       = addr[brot_pkg::ADDR_W-1:0];
         wr.data       = data[brot_pkg::BYTE_W-1:0];
         wr.mask       = mask[brot_pkg::BYTE_W-1:0];
         wr.run_last   = 1'b0;
         wr.frame_last = is_end;
         expected_writes.push_back(wr);
      endfunction

      // Works out the writes caused by one source byte and advances the counters.
      function void predict_writes(logic [brot_pkg::BYTE_W-1:0] b);
         int unsigned pixels, w, h, y, x, col, px, pos, pix_bytes, n_queued;
         bit row_ok, last_row;
         dst_write_type last_wr;
         pixels   = b;
         w        = (src_width > MAX_SIDE) ? MAX_SIDE : src_width;
         h        = (src_height > MAX_SIDE) ? MAX_SIDE : src_height;
         y        = row_y;
         x        = col_x;
         row_ok   = y < h;
         col      = row_ok ? h - 1 - y : 0;
         last_row = row_ok && (y + 1 == h);
         n_queued = expected_writes.size();
         case (bpp_mode)
            brot_pkg::MODE_1BPP: begin
               for (int i = 0; i < 8; i++) begin
                  px = x + i;
                  if (row_ok && px < w) begin
                     pos = 7 - (col & 7);
                     add_write(dst_stride * px + (col >> 3),
                               ((pixels >> (7 - i)) & 1) << pos,
                               int'(brot_pkg::BIT_MASK) << pos, last_row && px + 1 == w);
                  end
               end
               if (x < w) col_x = (x + 8 > w) ? w : x + 8;
            end
            brot_pkg::MODE_4BPP: begin
               for (int i = 0; i < 2; i++) begin
                  px = x + i;
                  if (row_ok && px < w) begin
                     pos = (col & 1) ? 0 : 4;
                     add_write(dst_stride * px + (col >> 1),
                               ((pixels >> ((i == 0) ? 4 : 0)) & 15) << pos,
                               int'(brot_pkg::NIBBLE_MASK) << pos,
                               last_row && px + 1 == w);
                  end
               end
               if (x < w) col_x = (x + 2 > w) ? w : x + 2;
            end
            brot_pkg::MODE_8BPP, brot_pkg::MODE_16BPP,
            brot_pkg::MODE_24BPP, brot_pkg::MODE_32BPP: begin
               // one byte per pixel at 8 bpp up to four at 32 bpp
               pix_bytes = bpp_mode - brot_pkg::MODE_4BPP;
               if (x < w) begin
                  if (row_ok)
                     add_write(dst_stride * x + pix_bytes * col + pixel_byte, pixels,
                               brot_pkg::FULL_MASK,
                               last_row && x + 1 == w && pixel_byte + 1 >= pix_bytes);
                  if (pixel_byte + 1 >= pix_bytes) begin
                     pixel_byte = 0;
                     col_x      = x + 1;
                  end else begin
                     pixel_byte = (pixel_byte + 1) & 3;
                  end
               end
            end
            default: ;   // reserved formats write nothing
         endcase
         if (expected_writes.size() > n_queued) begin
            last_wr = expected_writes.pop_back();
            last_wr.run_last = 1'b1;
            expected_writes.push_back(last_wr);
         end
         if (row_byte + 1 >= src_stride) begin
            row_byte   = 0;
            col_x      = 0;
            pixel_byte = 0;
            row_y      = (y + 1 >= h) ? 0 : y + 1;
         end else begin
            row_byte++;
         end
      endfunction

      task report(string msg);
         mismatches++;
         $display("%0t ERROR %s", $time, msg);
      endtask

      task check_write(logic [brot_pkg::RSP_TDATA_W-1:0] tdata, logic tlast, logic tuser);
         dst_write_type want;
         if (expected_writes.size() == 0) begin
            report($sformatf("unexpected write to 0x%0h", tdata[brot_pkg::ADDR_W-1:0]));
         end else begin
            want = expected_writes.pop_front();
            if (tdata[brot_pkg::ADDR_W-1:0] != want.addr)
               report($sformatf("dst_addr 0x%0h, want 0x%0h",
                                tdata[brot_pkg::ADDR_W-1:0], want.addr));
            if (tdata[brot_pkg::ADDR_W +: brot_pkg::BYTE_W] != want.data)
               report($sformatf("write_data 0x%0h, want 0x%0h at 0x%0h",
                                tdata[brot_pkg::ADDR_W +: brot_pkg::BYTE_W], want.data,
                                want.addr));
            if (tdata[brot_pkg::ADDR_W+brot_pkg::BYTE_W +: brot_pkg::BYTE_W] != want.mask)
               report($sformatf("write_mask 0x%0h, want 0x%0h at 0x%0h",
                                tdata[brot_pkg::ADDR_W+brot_pkg::BYTE_W +: brot_pkg::BYTE_W],
                                want.mask, want.addr));
            if (tlast != want.run_last)
               report($sformatf("run_last %0b, want %0b at 0x%0h", tlast, want.run_last,
                                want.addr));
            if (tuser != want.frame_last)
               report($sformatf("frame_last %0b, want %0b at 0x%0h", tuser, want.frame_last,
                                want.addr));
         end
      endtask
   endclass

   logic                                 clock = 1'b0;
   logic                                 reset = 1'b1;
   logic                                 req_tvalid = 1'b0;
   logic                                 req_tready;
   logic [brot_pkg::BYTE_W-1:0]          req_tdata = '0;
   logic                                 rsp_tvalid;
   logic                                 rsp_tready = 1'b0;
   logic [brot_pkg::RSP_TDATA_W-1:0]     rsp_tdata;
   logic                                 rsp_tlast;
   logic [0:0]                           rsp_tuser;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [brot_pkg::CSR_INDEX_W-1:0]     csr_index = '0;
   logic [brot_pkg::CSR_DATA_W-1:0]      csr_data = '0;

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int quiet_cycles       = 0;

   rotation_checker rotator = new();

   bitmap_rotate_90 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) rotator.set_reg(csr_index, csr_data);
         if (req_tvalid && req_tready) rotator.predict_writes(req_tdata);
         if (rsp_tvalid && rsp_tready) rotator.check_write(rsp_tdata, rsp_tlast, rsp_tuser[0]);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("bitmap_rotate_90_tb NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic set_idling(input int phase_no);
      case (phase_no % 4)
         0: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 0;
         end
         1: begin
            sender_idle_pct    = 48;
            receiver_stall_pct = 0;
         end
         2: begin
            sender_idle_pct    = 0;
            receiver_stall_pct = 48;
         end
         default: begin
            sender_idle_pct    = 22;
            receiver_stall_pct = 22;
         end
      endcase
   endtask

   // leaves csr_valid high so back-to-back writes never drop it for a step
   task automatic write_csr(input logic [brot_pkg::CSR_INDEX_W-1:0] sel,
                            input logic [brot_pkg::CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= sel;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_geometry(input int w, h, ss, ds, mode);
      write_csr(brot_pkg::REG_SRC_WIDTH, 15'(w));
      write_csr(brot_pkg::REG_SRC_HEIGHT, 15'(h));
      write_csr(brot_pkg::REG_SRC_STRIDE, 15'(ss));
      write_csr(brot_pkg::REG_DST_STRIDE, 15'(ds));
      write_csr(brot_pkg::REG_BPP_MODE, 15'(mode));
      csr_valid <= 1'b0;
   endtask

   task automatic push_src_byte(input logic [brot_pkg::BYTE_W-1:0] value);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      do @(posedge clock); while (!req_tready);
   endtask

   // Waits for every predicted write with the input idle, then lets the pipe clear.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (rotator.expected_writes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input int w, h, ss, ds, mode, n, input bit edge_data);
      load_geometry(w, h, ss, ds, mode);
      for (int i = 0; i < n; i++)
         push_src_byte(edge_data ? EDGE_BYTES[8 * (i % 8) +: 8] : 8'($urandom_range(0, 255)));
      settle();
   endtask

   task automatic random_phase(output int n);
      int w, h, ss, ds, mode, w_eff, h_eff, need, frame;
      mode = ($urandom_range(11) == 0) ? $urandom_range(6, 7) : $urandom_range(0, 5);
      case ($urandom_range(15))
         0: w = 0;
         1: w = 4096;
         2: w = 8191;
         3: w = $urandom_range(0, 32767);
         default: w = $urandom_range(1, 24);
      endcase
      case ($urandom_range(15))
         0: h = 0;
         1: h = 4096;
         2: h = 8191;
         3: h = $urandom_range(0, 32767);
         default: h = $urandom_range(1, 5);
      endcase
      w_eff = (w % 8192 > 4096) ? 4096 : w % 8192;
      h_eff = (h % 8192 > 4096) ? 4096 : h % 8192;
      // bytes that carry the pixels of one row
      if (mode == brot_pkg::MODE_1BPP)
         need = (w_eff + 7) / 8;
      else if (mode == brot_pkg::MODE_4BPP)
         need = (w_eff + 1) / 2;
      else if (mode <= brot_pkg::MODE_32BPP)
         need = w_eff * (mode - brot_pkg::MODE_4BPP);
      else
         need = w_eff;
      case ($urandom_range(15))
         0: ss = 0;
         1: ss = 32767;
         2: ss = 16384;
         3: ss = $urandom_range(1, need + 1);
         default: ss = need + $urandom_range(0, 3);
      endcase
      case ($urandom_range(15))
         0: ds = 0;
         1: ds = 32767;
         2: ds = 16384;
         3: ds = $urandom_range(0, 32767);
         default: ds = $urandom_range(1, 40);
      endcase
      // whole frames where they are short, otherwise a slice
      frame = h_eff * ((ss == 0) ? 1 : ss);
      if (frame > 0 && frame <= 96)
         n = frame * $urandom_range(1, 2);
      else
         n = $urandom_range(4, 48);
      run_phase(w, h, ss, ds, mode, n, 1'b0);
   endtask

   initial begin
      int random_items;
      int phase_no;
      int n;
      random_items = 0;
      phase_no     = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      set_idling(0);

      // geometry out of reset: one 8 bpp pixel per four-byte row
      for (int i = 0; i < 4; i++) push_src_byte(EDGE_BYTES[8 * i +: 8]);
      settle();
      write_csr(REG_UNMAPPED, '1);
      run_phase(11, 2, 2, 3, brot_pkg::MODE_1BPP, 4, 1'b1);
      run_phase(3, 1, 3, 2, brot_pkg::MODE_4BPP, 3, 1'b1);
      run_phase(1, 1, 3, 4, brot_pkg::MODE_16BPP, 3, 1'b1);
      run_phase(1, 1, 3, 4, brot_pkg::MODE_24BPP, 3, 1'b1);
      run_phase(1, 1, 4, 4, brot_pkg::MODE_32BPP, 4, 1'b1);
      run_phase(2, 1, 1, 4, MODE_RSVD6, 1, 1'b1);
      run_phase(2, 1, 1, 4, MODE_RSVD7, 1, 1'b1);
      // oversized sides clamp, top source row lands in the last column
      run_phase(8191, 8191, 32767, 0, brot_pkg::MODE_8BPP, 1, 1'b1);
      // no rows and zero stride: nothing written, row ends on every byte
      run_phase(1, 0, 0, 4, brot_pkg::MODE_8BPP, 1, 1'b1);

      // long 1 bpp row, short stride: dst_stride * x runs past the address width
      set_idling(3);
      run_phase(4096, 2, 258, 32767, brot_pkg::MODE_1BPP, 258, 1'b0);

      // the directed part above sends 283 items
      while (phase_no < 4 || random_items < 60) begin
         set_idling(phase_no);
         random_phase(n);
         random_items += n;
         phase_no++;
      end

      if (rotator.mismatches == 0)
         $display("bitmap_rotate_90_tb OK");
      else
         $display("bitmap_rotate_90_tb NOT OK");
      $finish;
   end

endmodule

// ===== filelist.f =====
hw/rtl/brot_pkg.sv
hw/rtl/brot_front.sv
hw/rtl/brot_queue.sv
hw/rtl/brot_back.sv
hw/rtl/bitmap_rotate_90.sv
dv/bitmap_rotate_90_tb.sv
